/* hdl/ifd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types, register codes, thresholds and helpers of the IMU fall
// detector.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int NUM_AXES            = 6;
  localparam int QUEUE_DEPTH_DEFAULT = 8;
  localparam int FRONT_STAGES        = 3;

  typedef enum logic [2:0] {
    REG_ACCEL_OFFSET_X = 3'd0,
    REG_ACCEL_OFFSET_Y = 3'd1,
    REG_ACCEL_OFFSET_Z = 3'd2,
    REG_GYRO_OFFSET_X  = 3'd3,
    REG_GYRO_OFFSET_Y  = 3'd4,
    REG_GYRO_OFFSET_Z  = 3'd5,
    REG_STAGE_WINDOW   = 3'd6,
    REG_SETTLE_DELAY   = 3'd7
  } reg_index_t;

  localparam logic [15:0] ACCEL_OFFSET_X_RESET = 16'd2050;
  localparam logic [15:0] ACCEL_OFFSET_Y_RESET = 16'd77;
  localparam logic [15:0] ACCEL_OFFSET_Z_RESET = 16'd1947;
  localparam logic [15:0] GYRO_OFFSET_X_RESET  = 16'hFEF2;  // -270
  localparam logic [15:0] GYRO_OFFSET_Y_RESET  = 16'd351;
  localparam logic [15:0] GYRO_OFFSET_Z_RESET  = 16'hFF78;  // -136
  localparam logic [7:0]  STAGE_WINDOW_RESET   = 8'd6;
  localparam logic [7:0]  SETTLE_DELAY_RESET   = 8'd10;

  // Squared thresholds on the sum of three squared axis differences.
  localparam logic [33:0] ACC_LOW_SQ   = 34'd24159191;
  localparam logic [33:0] ACC_HIGH_SQ  = 34'd386547057;
  localparam logic [33:0] GYR_MIN_SQ   = 34'd15461411;
  localparam logic [33:0] GYR_MAX_SQ   = 34'd2762455839;
  localparam logic [33:0] GYR_STILL_SQ = 34'd2078700;

  typedef struct packed {
    logic [NUM_AXES-1:0][15:0] offset;
    logic [7:0]                stage_window;
    logic [7:0]                settle_delay;
  } cfg_t;

  typedef struct packed {
    logic acc_low;
    logic acc_high;
    logic swing;
    logic still;
  } class_t;

  function automatic logic [31:0] square17(input logic signed [16:0] d);
    logic signed [33:0] w;
    w = 34'(d) * 34'(d);
    return w[31:0];
  endfunction

endpackage

/* hdl/ifd_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_sample_if
// Valid/ready channel carrying one raw six-axis sample per transaction.
// ----------------------------------------------------------------------------
interface ifd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

/* hdl/ifd_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_result_if
// Valid/ready channel carrying the detector flags of one sample per
// transaction.
// ----------------------------------------------------------------------------
interface ifd_result_if;
  logic valid;
  logic ready;
  logic fall_detected;
  logic free_fall_active;
  logic impact_active;
  logic settle_active;

  modport source (output valid, fall_detected, free_fall_active, impact_active,
                  settle_active, input ready);
  modport sink (input valid, fall_detected, free_fall_active, impact_active,
                settle_active, output ready);
endinterface

/* hdl/imu_fall_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fall_detector_core
// Three-stage fall detector on calibrated six-axis IMU samples.
//
// samples: one raw sample per transaction (valid/ready).
// result:  one transaction per sample with the latched fall flag and the
//          free-fall, impact and settle stage flags after that sample.
// wr_en/wr_index/wr_data: calibration offsets, stage window and settle delay;
//          write only while no sample is in flight.
// Path: with the queue empty, a sample passes the 3 classifier registers, the
// first loaded on the accepting edge, then the queue and the output register
// before result valid.
// Throughput: one sample per cycle while samples.ready is high; the sequencer
// updates the stages on every pop, and the classifier is fully pipelined.
// samples.ready is credit based: it drops when queued plus in-flight samples
// fill the QUEUE_DEPTH-entry queue, so a stalled result side backs up there.
// Reset clears all stage state, empties the queue, clears the output valid
// bit, and reloads the register defaults.
// ----------------------------------------------------------------------------
module imu_fall_detector_core
  import ifd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ifd_sample_if.sink    samples,
  ifd_result_if.source  result,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [15:0]   wr_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t                        cfg;
  logic                        take;
  logic [NUM_AXES-1:0][15:0]   axis;
  logic                        push, pop, empty;
  class_t                      push_class, head;
  logic [1:0]                  inflight;
  logic [CW-1:0]               count;
  logic [CW+1:0]               occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset[0]    <= ACCEL_OFFSET_X_RESET;
      cfg.offset[1]    <= ACCEL_OFFSET_Y_RESET;
      cfg.offset[2]    <= ACCEL_OFFSET_Z_RESET;
      cfg.offset[3]    <= GYRO_OFFSET_X_RESET;
      cfg.offset[4]    <= GYRO_OFFSET_Y_RESET;
      cfg.offset[5]    <= GYRO_OFFSET_Z_RESET;
      cfg.stage_window <= STAGE_WINDOW_RESET;
      cfg.settle_delay <= SETTLE_DELAY_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_ACCEL_OFFSET_X: cfg.offset[0]    <= wr_data;
        REG_ACCEL_OFFSET_Y: cfg.offset[1]    <= wr_data;
        REG_ACCEL_OFFSET_Z: cfg.offset[2]    <= wr_data;
        REG_GYRO_OFFSET_X:  cfg.offset[3]    <= wr_data;
        REG_GYRO_OFFSET_Y:  cfg.offset[4]    <= wr_data;
        REG_GYRO_OFFSET_Z:  cfg.offset[5]    <= wr_data;
        REG_STAGE_WINDOW:   cfg.stage_window <= wr_data[7:0];
        REG_SETTLE_DELAY:   cfg.settle_delay <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign axis[0] = samples.accel_x;
  assign axis[1] = samples.accel_y;
  assign axis[2] = samples.accel_z;
  assign axis[3] = samples.gyro_x;
  assign axis[4] = samples.gyro_y;
  assign axis[5] = samples.gyro_z;

  assign occupancy     = (CW+2)'(count) + (CW+2)'(inflight);
  assign samples.ready = !rst && (occupancy < (CW+2)'(QUEUE_DEPTH));
  assign take          = samples.valid && samples.ready;

  ifd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .axis       (axis),
    .push       (push),
    .push_class (push_class),
    .inflight   (inflight)
  );

  ifd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_class (push_class),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .count      (count)
  );

  ifd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .avail  (!empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CW'(QUEUE_DEPTH))
    else $error("queue overrun");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_fall_sticky: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fall_detected |=> !result.valid || result.fall_detected)
    else $error("fall flag dropped");

  a_stage_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.free_fall_active && result.impact_active))
    else $error("free fall and impact both active");

endmodule

/* hdl/ifd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_front
// Three-stage classifier: offset subtract, square, sum; the sums are compared
// against the squared thresholds and pushed to the queue.
// ----------------------------------------------------------------------------
module ifd_front
  import ifd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         take,
  input  logic [NUM_AXES-1:0][15:0] axis,
  output logic         push,
  output class_t       push_class,
  output logic [1:0]   inflight
);

  logic                       s1_valid, s2_valid, s3_valid;
  logic signed [16:0]         diff [NUM_AXES];
  logic [31:0]                sq   [NUM_AXES];
  logic [33:0]                acc_sum, gyr_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] <= $signed({axis[i][15], axis[i]}) - $signed({cfg.offset[i][15], cfg.offset[i]});
      sq[i]   <= square17(diff[i]);
    end
    acc_sum <= 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
    gyr_sum <= 34'(sq[3]) + 34'(sq[4]) + 34'(sq[5]);
  end

  always_comb begin
    push_class.acc_low  = acc_sum <= ACC_LOW_SQ;
    push_class.acc_high = acc_sum >= ACC_HIGH_SQ;
    push_class.swing    = (gyr_sum >= GYR_MIN_SQ) && (gyr_sum <= GYR_MAX_SQ);
    push_class.still    = gyr_sum <= GYR_STILL_SQ;
  end

  assign push     = s3_valid;
  assign inflight = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);

endmodule

/* hdl/ifd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_queue
// Small FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module ifd_queue
  import ifd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  class_t                     push_class,
  input  logic                       pop,
  output class_t                     head,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  class_t          entry [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_class;
    end
  end

  assign head  = entry[rd_ptr];
  assign empty = (count == '0);

endmodule

/* hdl/ifd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_back
// Stage sequencer: advances free fall, impact and settle per classified
// sample and holds the result in an output register.
// ----------------------------------------------------------------------------
module ifd_back
  import ifd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               avail,
  input  class_t             head,
  output logic               pop,
  ifd_result_if.source       result
);

  logic       ff_flag, imp_flag, st_flag, latch;
  logic [7:0] ff_count, imp_count, st_count;
  logic       ff_flag_next, imp_flag_next, st_flag_next, latch_next;
  logic [7:0] ff_count_next, imp_count_next, st_count_next;
  logic       out_valid;

  assign pop = avail && (!out_valid || result.ready);

  always_comb begin
    ff_flag_next   = ff_flag;
    imp_flag_next  = imp_flag;
    st_flag_next   = st_flag;
    latch_next     = latch;
    ff_count_next  = ff_count;
    imp_count_next = imp_count;
    st_count_next  = st_count;

    if (head.acc_low && !imp_flag_next) begin
      ff_flag_next = 1'b1;
    end
    if (ff_flag_next) begin
      ff_count_next = ff_count_next + 8'd1;
      if (head.acc_high) begin
        imp_flag_next = 1'b1;
        ff_flag_next  = 1'b0;
        ff_count_next = '0;
      end
    end
    if (imp_flag_next) begin
      imp_count_next = imp_count_next + 8'd1;
      if (head.swing) begin
        st_flag_next   = 1'b1;
        imp_flag_next  = 1'b0;
        imp_count_next = '0;
      end
    end
    if (st_flag_next) begin
      st_count_next = st_count_next + 8'd1;
      if (st_count_next >= cfg.settle_delay) begin
        if (head.still) begin
          latch_next = 1'b1;
        end
        st_flag_next  = 1'b0;
        st_count_next = '0;
      end
    end
    if (!latch_next) begin
      if (imp_count_next >= cfg.stage_window) begin
        imp_flag_next  = 1'b0;
        imp_count_next = '0;
      end
      if (ff_count_next >= cfg.stage_window) begin
        ff_flag_next  = 1'b0;
        ff_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_flag   <= 1'b0;
      imp_flag  <= 1'b0;
      st_flag   <= 1'b0;
      latch     <= 1'b0;
      ff_count  <= '0;
      imp_count <= '0;
      st_count  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        ff_flag   <= ff_flag_next;
        imp_flag  <= imp_flag_next;
        st_flag   <= st_flag_next;
        latch     <= latch_next;
        ff_count  <= ff_count_next;
        imp_count <= imp_count_next;
        st_count  <= st_count_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.fall_detected    <= latch_next;
      result.free_fall_active <= ff_flag_next;
      result.impact_active    <= imp_flag_next;
      result.settle_active    <= st_flag_next;
    end
  end

  assign result.valid = out_valid;

endmodule

/* sim/ifd_fall_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_fall_checker
// Watches the sample, result and register channels of the IMU fall detector.
// Keeps its own copy of the calibration registers and the three-stage
// detector state, predicts the flags of every accepted sample and compares
// each result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ifd_fall_checker
  import ifd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ifd_sample_if       samples,
  ifd_result_if       result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output int          errors,
  output int          outstanding,
  output int          results_checked,
  output logic        fall_predicted
);

  localparam longint LOW_G_SQ     = 64'd24159191;
  localparam longint HIGH_G_SQ    = 64'd386547057;
  localparam longint SWING_MIN_SQ = 64'd15461411;
  localparam longint SWING_MAX_SQ = 64'd2762455839;
  localparam longint STILL_SQ     = 64'd2078700;

  typedef struct packed {
    logic fall;
    logic free_fall;
    logic impact;
    logic settle;
  } flags_t;

  flags_t             expected_flags [$];
  logic signed [15:0] offset [NUM_AXES];
  logic [7:0]         window;
  logic [7:0]         delay;
  logic               falling, impacted, settling, latched;
  logic [7:0]         fall_cnt, impact_cnt, settle_cnt;

  function automatic longint sq_dev(input logic signed [15:0] raw,
                                    input logic signed [15:0] off);
    longint d;
    d = longint'(raw) - longint'(off);
    return d * d;
  endfunction

  task automatic advance_detector(output flags_t f);
    longint acc, gyr;
    logic   acc_low, acc_high, swing, still;
    acc = sq_dev(samples.accel_x, offset[0]) + sq_dev(samples.accel_y, offset[1])
        + sq_dev(samples.accel_z, offset[2]);
    gyr = sq_dev(samples.gyro_x, offset[3]) + sq_dev(samples.gyro_y, offset[4])
        + sq_dev(samples.gyro_z, offset[5]);
    acc_low  = acc <= LOW_G_SQ;
    acc_high = acc >= HIGH_G_SQ;
    swing    = gyr >= SWING_MIN_SQ && gyr <= SWING_MAX_SQ;
    still    = gyr <= STILL_SQ;

    if (acc_low && !impacted) falling = 1'b1;
    if (falling) begin
      fall_cnt = fall_cnt + 8'd1;
      if (acc_high) begin
        impacted = 1'b1;
        falling  = 1'b0;
        fall_cnt = '0;
      end
    end
    if (impacted) begin
      impact_cnt = impact_cnt + 8'd1;
      if (swing) begin
        settling   = 1'b1;
        impacted   = 1'b0;
        impact_cnt = '0;
      end
    end
    if (settling) begin
      settle_cnt = settle_cnt + 8'd1;
      if (settle_cnt >= delay) begin
        if (still) latched = 1'b1;
        settling   = 1'b0;
        settle_cnt = '0;
      end
    end
    // hold both stage timeouts once a fall is latched
    if (!latched) begin
      if (impact_cnt >= window) begin
        impacted   = 1'b0;
        impact_cnt = '0;
      end
      if (fall_cnt >= window) begin
        falling  = 1'b0;
        fall_cnt = '0;
      end
    end

    f.fall      = latched;
    f.free_fall = falling;
    f.impact    = impacted;
    f.settle    = settling;
  endtask

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    flags_t want;
    if (rst) begin
      expected_flags.delete();
      offset[0]       = ACCEL_OFFSET_X_RESET;
      offset[1]       = ACCEL_OFFSET_Y_RESET;
      offset[2]       = ACCEL_OFFSET_Z_RESET;
      offset[3]       = GYRO_OFFSET_X_RESET;
      offset[4]       = GYRO_OFFSET_Y_RESET;
      offset[5]       = GYRO_OFFSET_Z_RESET;
      window          = STAGE_WINDOW_RESET;
      delay           = SETTLE_DELAY_RESET;
      falling         = 1'b0;
      impacted        = 1'b0;
      settling        = 1'b0;
      latched         = 1'b0;
      fall_cnt        = '0;
      impact_cnt      = '0;
      settle_cnt      = '0;
      errors          = 0;
      results_checked = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_flags.size() == 0) begin
          errors++;
          $display("%0t: result transaction with no sample outstanding", $time);
        end else begin
          want = expected_flags.pop_front();
          results_checked++;
          check_flag("fall_detected", want.fall, result.fall_detected);
          check_flag("free_fall_active", want.free_fall, result.free_fall_active);
          check_flag("impact_active", want.impact, result.impact_active);
          check_flag("settle_active", want.settle, result.settle_active);
        end
      end
      if (samples.valid && samples.ready) begin
        advance_detector(want);
        expected_flags.push_back(want);
      end
      if (wr_en) begin
        case (wr_index)
          REG_ACCEL_OFFSET_X: offset[0] = wr_data;
          REG_ACCEL_OFFSET_Y: offset[1] = wr_data;
          REG_ACCEL_OFFSET_Z: offset[2] = wr_data;
          REG_GYRO_OFFSET_X:  offset[3] = wr_data;
          REG_GYRO_OFFSET_Y:  offset[4] = wr_data;
          REG_GYRO_OFFSET_Z:  offset[5] = wr_data;
          REG_STAGE_WINDOW:   window    = wr_data[7:0];
          REG_SETTLE_DELAY:   delay     = wr_data[7:0];
          default: ;
        endcase
      end
    end
    outstanding    = expected_flags.size();
    fall_predicted = latched;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the IMU fall detector core. Drives directed
// full-scale samples, then shaped fall sequences (free fall, impact with
// rotation, settle) mixed with broken sequences and noise, under several
// register settings, with random idling on both channels, one long output
// stall and a post-latch stretch that wraps the stage counters.
// ----------------------------------------------------------------------------
module tb_top;
  import ifd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [NUM_AXES-1:0][15:0] sample_t;
  typedef enum {ACC_ANY, ACC_LOW, ACC_MID, ACC_HIGH} acc_kind_e;
  typedef enum {GYR_ANY, GYR_STILL, GYR_MID, GYR_SWING, GYR_OVER} gyr_kind_e;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  ifd_sample_if samples ();
  ifd_result_if result ();

  int   mismatches;
  int   outstanding;
  int   results_checked;
  logic fall_predicted;

  int   cur_off [NUM_AXES];
  int   cur_window;
  int   cur_delay;
  int   samples_sent = 0;
  int   settings_applied = 0;
  int   cycle_count = 0;
  bit   latch_ok = 0;
  bit   steady = 0;
  bit   stall_request = 0;
  bit   stall_done = 0;
  int   stall_left = 0;

  imu_fall_detector_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  ifd_fall_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .samples         (samples),
    .result          (result),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .errors          (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .fall_predicted  (fall_predicted)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial result.ready = 1'b0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_request && !stall_done) begin
      result.ready <= 1'b0;
      stall_left   <= 120;
      stall_done   <= 1'b1;
    end else begin
      result.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  function automatic int spread(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int magnitude(input int lo, input int hi);
    int m;
    m = int'($urandom_range(hi, lo));
    return $urandom_range(1) ? m : -m;
  endfunction

  function automatic logic [15:0] place(input int off, input int d);
    int v;
    v = off + d;
    if (v > 32767 || v < -32768) v = off - d;
    return 16'(v);
  endfunction

  function automatic sample_t random_offsets(input int span);
    sample_t s;
    for (int i = 0; i < NUM_AXES; i++) s[i] = 16'(spread(span));
    return s;
  endfunction

  function automatic gyr_kind_e pick_gyro();
    case ($urandom_range(3))
      0:       return latch_ok ? GYR_STILL : GYR_MID;
      1:       return GYR_MID;
      2:       return GYR_SWING;
      default: return GYR_OVER;
    endcase
  endfunction

  function automatic gyr_kind_e pick_quiet();
    case ($urandom_range(2))
      0:       return latch_ok ? GYR_STILL : GYR_OVER;
      1:       return GYR_MID;
      default: return GYR_OVER;
    endcase
  endfunction

  // offsets are added back so the calibrated values land in the chosen band
  function automatic sample_t make_sample(input acc_kind_e ak, input gyr_kind_e gk);
    sample_t s;
    int      d [NUM_AXES];
    bit      raw;
    for (int i = 0; i < NUM_AXES; i++) d[i] = spread(i < 3 ? 2500 : 800);
    case (ak)
      ACC_MID:  d[$urandom_range(2)] = magnitude(8000, 16000);
      ACC_HIGH: d[$urandom_range(2)] = magnitude(20000, 30000);
      default: ;
    endcase
    case (gk)
      GYR_MID: begin
        for (int i = 3; i < NUM_AXES; i++) d[i] = spread(300);
        d[3 + $urandom_range(2)] = magnitude(1500, 3800);
      end
      GYR_SWING: d[3 + $urandom_range(2)] = magnitude(4500, 30000);
      GYR_OVER:  for (int i = 3; i < NUM_AXES; i++) d[i] = magnitude(31000, 32767);
      default: ;
    endcase
    for (int i = 0; i < NUM_AXES; i++) begin
      raw  = (i < 3) ? (ak == ACC_ANY) : (gk == GYR_ANY);
      s[i] = raw ? 16'($urandom) : place(cur_off[i], d[i]);
    end
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(99) < 33) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid   <= 1'b1;
    samples.accel_x <= s[0];
    samples.accel_y <= s[1];
    samples.accel_z <= s[2];
    samples.gyro_x  <= s[3];
    samples.gyro_y  <= s[4];
    samples.gyro_z  <= s[5];
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    samples.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
  endtask

  task automatic apply_settings(input sample_t offs, input logic [7:0] w,
                                input logic [7:0] d);
    drain_results();
    write_reg(REG_ACCEL_OFFSET_X, offs[0]);
    write_reg(REG_ACCEL_OFFSET_Y, offs[1]);
    write_reg(REG_ACCEL_OFFSET_Z, offs[2]);
    write_reg(REG_GYRO_OFFSET_X, offs[3]);
    write_reg(REG_GYRO_OFFSET_Y, offs[4]);
    write_reg(REG_GYRO_OFFSET_Z, offs[5]);
    write_reg(REG_STAGE_WINDOW, {8'($urandom), w});
    write_reg(REG_SETTLE_DELAY, {8'($urandom), d});
    @(negedge clk);
    wr_en <= 1'b0;
    for (int i = 0; i < NUM_AXES; i++) cur_off[i] = int'($signed(offs[i]));
    cur_window = w;
    cur_delay  = d;
    settings_applied++;
  endtask

  // free fall, impact, rotation, settle; broken ones overstay a window or stop early
  task automatic run_fall(input bit broken, input bit allow_latch);
    int  span, n_fall, n_wait;
    bit  cut, swung;
    span   = (cur_window > 8) ? 8 : cur_window;
    cut    = broken && $urandom_range(1);
    n_fall = (span > 1) ? $urandom_range(span - 1, 1) : 1;
    n_wait = (span > 2) ? $urandom_range(span - 2) : 0;
    if (broken && !cut) begin
      if ($urandom_range(1)) n_fall = span + $urandom_range(3);
      else n_wait = span + $urandom_range(3);
    end
    send_sample(make_sample(ACC_LOW, pick_gyro()));
    for (int i = 1; i < n_fall; i++)
      send_sample(make_sample($urandom_range(1) ? ACC_LOW : ACC_MID, pick_gyro()));
    if (!cut) begin
      swung = $urandom_range(1);
      send_sample(make_sample(ACC_HIGH, swung ? GYR_SWING : GYR_MID));
      if (!swung) begin
        for (int i = 0; i < n_wait; i++) send_sample(make_sample(ACC_MID, pick_quiet()));
        send_sample(make_sample(ACC_MID, GYR_SWING));
      end
      for (int i = 1; i < cur_delay; i++)
        send_sample(make_sample(($urandom_range(7) == 0) ? ACC_LOW : ACC_MID,
                                (i == cur_delay - 1) ? (allow_latch ? GYR_STILL : GYR_MID)
                                                     : pick_gyro()));
    end
  endtask

  task automatic run_traffic(input int target, input bit allow_latch);
    int start, r;
    start = samples_sent;
    while (samples_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 65) run_fall(1'b0, allow_latch);
      else if (r < 85) run_fall(1'b1, 1'b0);
      else repeat ($urandom_range(4, 1)) send_sample(make_sample(ACC_ANY, GYR_ANY));
    end
  endtask

  initial begin : stimulus
    int tries;
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = REG_ACCEL_OFFSET_X;
    wr_data         = '0;
    samples.valid   = 1'b0;
    samples.accel_x = '0;
    samples.accel_y = '0;
    samples.accel_z = '0;
    samples.gyro_x  = '0;
    samples.gyro_y  = '0;
    samples.gyro_z  = '0;
    cur_off[0]      = int'($signed(ACCEL_OFFSET_X_RESET));
    cur_off[1]      = int'($signed(ACCEL_OFFSET_Y_RESET));
    cur_off[2]      = int'($signed(ACCEL_OFFSET_Z_RESET));
    cur_off[3]      = int'($signed(GYRO_OFFSET_X_RESET));
    cur_off[4]      = int'($signed(GYRO_OFFSET_Y_RESET));
    cur_off[5]      = int'($signed(GYRO_OFFSET_Z_RESET));
    cur_window      = STAGE_WINDOW_RESET;
    cur_delay       = SETTLE_DELAY_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_sample('0);
    send_sample({NUM_AXES{16'h7FFF}});
    send_sample({NUM_AXES{16'h8000}});
    send_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
    send_sample({NUM_AXES{16'h5555}});
    send_sample({NUM_AXES{16'hAAAA}});
    send_sample({GYRO_OFFSET_Z_RESET, GYRO_OFFSET_Y_RESET, GYRO_OFFSET_X_RESET,
                 ACCEL_OFFSET_Z_RESET, ACCEL_OFFSET_Y_RESET, ACCEL_OFFSET_X_RESET});
    send_sample(make_sample(ACC_HIGH, GYR_SWING));
    // free-fall window runs out
    send_sample(make_sample(ACC_LOW, GYR_STILL));
    repeat (6) send_sample(make_sample(ACC_MID, GYR_MID));
    // impact window runs out
    send_sample(make_sample(ACC_LOW, GYR_MID));
    send_sample(make_sample(ACC_HIGH, GYR_MID));
    repeat (5) send_sample(make_sample(ACC_MID, GYR_MID));

    apply_settings(random_offsets(3000), 8'($urandom_range(10, 4)), 8'd10);
    steady <= 1'b1;
    run_traffic(100, 1'b0);
    steady <= 1'b0;
    run_traffic(60, 1'b0);

    apply_settings({16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF},
                   8'd255, 8'd255);
    run_traffic(260, 1'b0);

    apply_settings(random_offsets(2000), 8'd0, 8'd0);
    run_traffic(60, 1'b0);

    apply_settings(random_offsets(2000), 8'd1, 8'd1);
    run_traffic(80, 1'b0);

    apply_settings(random_offsets(8000), 8'($urandom_range(20, 2)),
                   8'($urandom_range(20, 2)));
    stall_request <= 1'b1;
    run_traffic(150, 1'b0);

    latch_ok = 1'b1;
    apply_settings(random_offsets(1500), 8'd8, 8'd5);
    tries = 0;
    while (!fall_predicted && tries < 40) begin
      run_fall(1'b0, 1'b1);
      tries++;
    end
    // wrap the impact counter, then the free-fall counter, with timeouts held
    send_sample(make_sample(ACC_LOW, GYR_MID));
    send_sample(make_sample(ACC_HIGH, GYR_MID));
    repeat (265) send_sample(make_sample(ACC_MID, GYR_MID));
    send_sample(make_sample(ACC_MID, GYR_SWING));
    send_sample(make_sample(ACC_LOW, GYR_MID));
    repeat (265) send_sample(make_sample(ACC_MID, GYR_MID));

    drain_results();
    $display("Run: %0d samples under %0d register settings, %0d results compared",
             samples_sent, settings_applied, results_checked);
    $display("Scope: zero and full-scale window and delay, extreme offsets, output stall, %s",
             fall_predicted ? "latched fall with counter wrap" : "no latched fall");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
